>>> hw/rtl/rtce_pkg.sv
// ----------------------------------------------------------------------------
// rtce_pkg
// Constants, register codes and helper functions for the calendar-to-epoch
// conversion pipeline.
// ----------------------------------------------------------------------------
package rtce_pkg;

  // Calendar constants
  localparam int unsigned EpochYear     = 1970;
  localparam int unsigned BaseYear      = 1900;
  localparam int unsigned WindowYear    = 1970;
  localparam int unsigned CenturyYears  = 100;
  localparam int unsigned DaysPerYear   = 365;
  localparam int unsigned MinsPerDay    = 24 * 60;
  localparam int unsigned SecsPerMin    = 60;
  localparam int unsigned MaxHour       = 23;
  localparam int unsigned MaxDay        = 31;
  localparam int unsigned MaxMonth      = 12;
  localparam int unsigned EpochLeapBase = (EpochYear - 1) / 4;

  // Datapath widths
  localparam int unsigned FieldW = 8;
  localparam int unsigned YearW  = 12;
  localparam int unsigned DaysW  = 17;
  localparam int unsigned HmW    = 11;
  localparam int unsigned MinW   = 28;
  localparam int unsigned SecW   = 33;

  // Configuration port
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  typedef enum logic {
    RegClockPresent = 1'b0,
    RegBinaryFields = 1'b1
  } reg_idx_e;

  // Packed BCD (tens in the high nibble, no digit check) or plain binary
  function automatic logic [FieldW-1:0] decode_field(input logic [FieldW-1:0] raw,
                                                     input logic binary);
    logic [FieldW-1:0] tens;
    tens = {1'b0, raw[7:4], 3'b000} + {3'b000, raw[7:4], 1'b0};
    return binary ? raw : tens + {4'b0000, raw[3:0]};
  endfunction

  // Days in the year before the first of month m (1..12)
  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

>>> hw/rtl/rtc_calendar_to_epoch_seconds_top.sv
// ----------------------------------------------------------------------------
// rtc_calendar_to_epoch_seconds_top
// Turns one snapshot of RTC calendar bytes into seconds since the epoch year.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle unless the output stalls; the four-stage
// pipeline (decode, day count, minute count, second count) each holds one word
// and advances independently.
// Reset clears every stage valid bit and both configuration registers
// (clock absent, BCD fields); payload registers are not reset.
module rtc_calendar_to_epoch_seconds_top
  import rtce_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [FieldW-1:0]   second_raw_i,
  input  logic [FieldW-1:0]   minute_raw_i,
  input  logic [FieldW-1:0]   hour_raw_i,
  input  logic [FieldW-1:0]   day_raw_i,
  input  logic [FieldW-1:0]   month_raw_i,
  input  logic [FieldW-1:0]   year_raw_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SecW-1:0]     epoch_seconds_o,
  output logic                valid_res_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic clock_present_q, clock_present_d;
  logic binary_fields_q, binary_fields_d;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    clock_present_d = clock_present_q;
    binary_fields_d = binary_fields_q;
    prdata          = '0;
    unique case (reg_idx_e'(paddr[2])) 
      RegClockPresent: begin
        prdata[0] = clock_present_q;
        if (cfg_wr) begin
          clock_present_d = pwdata[0];
        end
      end
      RegBinaryFields: begin
        prdata[0] = binary_fields_q;
        if (cfg_wr) begin
          binary_fields_d = pwdata[0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_present_q <= 1'b0;
      binary_fields_q <= 1'b0;
    end else begin
      clock_present_q <= clock_present_d;
      binary_fields_q <= binary_fields_d;
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: a stage takes a new word when it is empty or its word moves
  // on in the same cycle. Only a stalled output word can back the chain up.
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s1_rdy, s2_rdy, s3_rdy, out_rdy;

  assign out_rdy    = !out_valid_q || !out_stall_i;
  assign s3_rdy     = !s3_valid_q  || out_rdy;
  assign s2_rdy     = !s2_valid_q  || s3_rdy;
  assign s1_rdy     = !s1_valid_q  || s2_rdy;
  assign in_stall_o = !s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_rdy) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_rdy) begin
        s3_valid_q <= s2_valid_q;
      end
      if (out_rdy) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: decode the bytes, range check, window the year
  // --------------------------------------------------------------------------
  logic [FieldW-1:0] sec_dec, min_dec, hour_dec, day_dec, month_dec, year_dec;
  logic              ok_d;
  logic [YearW-1:0]  year_d;

  logic              s1_ok_q;
  logic [YearW-1:0]  s1_year_q;
  logic [3:0]        s1_month_q;
  logic [4:0]        s1_day_q;
  logic [4:0]        s1_hour_q;
  logic [FieldW-1:0] s1_min_q;
  logic [FieldW-1:0] s1_sec_q;

  always_comb begin
    sec_dec   = decode_field(second_raw_i, binary_fields_q);
    min_dec   = decode_field(minute_raw_i, binary_fields_q);
    hour_dec  = decode_field(hour_raw_i,   binary_fields_q);
    day_dec   = decode_field(day_raw_i,    binary_fields_q);
    month_dec = decode_field(month_raw_i,  binary_fields_q);
    year_dec  = decode_field(year_raw_i,   binary_fields_q);

    // Seconds and minutes go through unchecked; a day past the month end
    // simply counts on into the next month.
    ok_d = clock_present_q
         && (hour_dec  <= FieldW'(MaxHour))
         && (day_dec   != '0) && (day_dec   <= FieldW'(MaxDay))
         && (month_dec != '0) && (month_dec <= FieldW'(MaxMonth));

    // Two-digit year: 70 and up counts on from 1900, below that from 2000
    year_d = {{(YearW-FieldW){1'b0}}, year_dec} + YearW'(BaseYear);
    if (year_dec < FieldW'(WindowYear - BaseYear)) begin
      year_d = year_d + YearW'(CenturyYears);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      s1_ok_q    <= ok_d;
      s1_year_q  <= year_d;
      s1_month_q <= month_dec[3:0];
      s1_day_q   <= day_dec[4:0];
      s1_hour_q  <= hour_dec[4:0];
      s1_min_q   <= min_dec;
      s1_sec_q   <= sec_dec;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: whole days since the epoch, and minutes within the day
  // --------------------------------------------------------------------------
  logic [YearW-1:0] year_diff;
  logic [YearW-1:0] year_m1;
  logic [DaysW-1:0] year_days;
  logic [DaysW-1:0] days_d;
  logic [HmW-1:0]   hm_d;

  logic              s2_ok_q;
  logic [DaysW-1:0]  s2_days_q;
  logic [HmW-1:0]    s2_hm_q;
  logic [FieldW-1:0] s2_sec_q;

  always_comb begin
    year_diff = s1_year_q - YearW'(EpochYear);
    year_m1   = s1_year_q - YearW'(1);
    // Years before the epoch year count no whole years
    year_days = '0;
    if (s1_year_q > YearW'(EpochYear)) begin
      year_days = DaysW'(year_diff) * DaysW'(DaysPerYear)
                + DaysW'(year_m1 >> 2) - DaysW'(EpochLeapBase);
    end
    days_d = year_days
           + DaysW'(days_before_month(s1_month_q))
           + DaysW'(s1_day_q) - DaysW'(1);
    // Leap day once past February, every fourth year without exception
    if ((s1_year_q[1:0] == 2'b00) && (s1_month_q > 4'd2)) begin
      days_d = days_d + DaysW'(1);
    end
    hm_d = HmW'(s1_hour_q) * HmW'(SecsPerMin) + HmW'(s1_min_q);
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy) begin
      s2_ok_q   <= s1_ok_q;
      s2_days_q <= days_d;
      s2_hm_q   <= hm_d;
      s2_sec_q  <= s1_sec_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: total minutes
  // --------------------------------------------------------------------------
  logic [MinW-1:0]   mins_d;
  logic              s3_ok_q;
  logic [MinW-1:0]   s3_mins_q;
  logic [FieldW-1:0] s3_sec_q;

  assign mins_d = MinW'(s2_days_q) * MinW'(MinsPerDay) + MinW'(s2_hm_q);

  always_ff @(posedge clk_i) begin
    if (s3_rdy) begin
      s3_ok_q   <= s2_ok_q;
      s3_mins_q <= mins_d;
      s3_sec_q  <= s2_sec_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: total seconds into the output register; drop the value to zero
  // for a failed word.
  // --------------------------------------------------------------------------
  logic [SecW-1:0] secs_d;
  logic [SecW-1:0] out_secs_q;
  logic            out_ok_q;

  assign secs_d = s3_ok_q ? SecW'(s3_mins_q) * SecW'(SecsPerMin) + SecW'(s3_sec_q)
                          : '0;

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      out_ok_q   <= s3_ok_q;
      out_secs_q <= secs_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign epoch_seconds_o = out_secs_q;
  assign valid_res_o     = out_ok_q;

endmodule

>>> hw/rtl/rtce_checker.sv
// ----------------------------------------------------------------------------
// rtce_checker
// Port-level checks for the calendar-to-epoch pipeline, bound to the top.
// ----------------------------------------------------------------------------
module rtce_checker
  import rtce_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [AddrW-1:0]  paddr,
  input logic [DataW-1:0]  pwdata,
  input logic [DataW-1:0]  prdata,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [SecW-1:0]   epoch_seconds_o,
  input logic              valid_res_o
);

  // A failed conversion always carries a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |-> (epoch_seconds_o == '0))
    else $error("invalid result with non-zero seconds");

  // Hold a stalled output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(epoch_seconds_o) && $stable(valid_res_o)))
    else $error("stalled output word changed");

  // The input side backs up only behind a stalled output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with output free");

  // A write to the clock-present register reads back next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && !paddr[2]) |=>
      (paddr[2] || (prdata[0] == $past(pwdata[0]))))
    else $error("clock-present register read-back mismatch");

endmodule

bind rtc_calendar_to_epoch_seconds_top rtce_checker u_rtce_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .prdata          (prdata),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .epoch_seconds_o (epoch_seconds_o),
  .valid_res_o     (valid_res_o)
);

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// Calendar-to-epoch conversion testbench
// Drives RTC calendar snapshots (packed BCD and plain binary, with and without
// a working clock) into the pipeline, predicts every conversion on the side
// and checks each result word field by field. Random idling on both channels
// and one long receiver hold-off exercise the pipeline's flow control.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtce_pkg::*;

  localparam int QuietLimit = 5000;  // cycles with no accepted word before giving up
  localparam int HoldCycles = 300;   // length of the long receiver hold-off
  localparam int DrainCycles = 10;   // settle time after the last result

  // One calendar snapshot, as the RTC presents it
  typedef struct packed {
    logic [FieldW-1:0] second_b;
    logic [FieldW-1:0] minute_b;
    logic [FieldW-1:0] hour_b;
    logic [FieldW-1:0] day_b;
    logic [FieldW-1:0] month_b;
    logic [FieldW-1:0] year_b;
  } rtc_snapshot_t;

  // One conversion result
  typedef struct packed {
    logic [SecW-1:0] secs;
    logic            ok;
  } epoch_word_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Configuration port
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [AddrW-1:0]  paddr   = '0;
  logic [DataW-1:0]  pwdata  = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  // Input channel
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  logic [FieldW-1:0] second_raw_i = '0;
  logic [FieldW-1:0] minute_raw_i = '0;
  logic [FieldW-1:0] hour_raw_i   = '0;
  logic [FieldW-1:0] day_raw_i    = '0;
  logic [FieldW-1:0] month_raw_i  = '0;
  logic [FieldW-1:0] year_raw_i   = '0;

  // Output channel
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  logic [SecW-1:0]   epoch_seconds_o;
  logic              valid_res_o;

  // Snapshots waiting to be offered, and conversions waiting to come out
  rtc_snapshot_t snapshots_pending[$];
  epoch_word_t   conversions_due[$];

  // Shadow of the configuration registers
  bit cfg_present = 1'b0;
  bit cfg_binary  = 1'b0;

  // Flow-control knobs for the current phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_wanted    = 1'b0;
  bit          hold_done      = 1'b0;
  int unsigned hold_left      = 0;

  // Bookkeeping
  int unsigned words_in      = 0;
  int unsigned words_out     = 0;
  int unsigned valid_seen    = 0;
  int unsigned rejected_seen = 0;
  int unsigned mismatches    = 0;
  int unsigned settings_run  = 0;
  int unsigned seen_in       = 0;
  int unsigned seen_out      = 0;
  int unsigned quiet_cycles  = 0;

  rtc_calendar_to_epoch_seconds_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .second_raw_i    (second_raw_i),
    .minute_raw_i    (minute_raw_i),
    .hour_raw_i      (hour_raw_i),
    .day_raw_i       (day_raw_i),
    .month_raw_i     (month_raw_i),
    .year_raw_i      (year_raw_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .epoch_seconds_o (epoch_seconds_o),
    .valid_res_o     (valid_res_o)
  );

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Decode one register byte: plain binary, or two BCD digits with no check
  // on the digits, so a nibble above nine still counts at face value.
  function automatic int unsigned field_value(input logic [FieldW-1:0] raw, input bit binary);
    if (binary)
      return int'(raw);
    return int'(raw[7:4]) * 10 + int'(raw[3:0]);
  endfunction

  // Seconds since the start of the epoch year for one snapshot.
  function automatic epoch_word_t calendar_to_seconds(input rtc_snapshot_t s,
                                                      input bit present, input bit binary);
    int unsigned     sec_v;
    int unsigned     min_v;
    int unsigned     hour_v;
    int unsigned     day_v;
    int unsigned     mon_v;
    int unsigned     year_v;
    int unsigned     month_start;
    longint unsigned days;
    longint unsigned total;
    epoch_word_t     r;
    r      = '0;
    sec_v  = field_value(s.second_b, binary);
    min_v  = field_value(s.minute_b, binary);
    hour_v = field_value(s.hour_b, binary);
    day_v  = field_value(s.day_b, binary);
    mon_v  = field_value(s.month_b, binary);
    year_v = field_value(s.year_b, binary) + BaseYear;
    // Reject on a missing clock or an hour, day or month out of range;
    // seconds, minutes and the day against the month's length go unchecked.
    if (!present || hour_v > MaxHour || day_v < 1 || day_v > MaxDay ||
        mon_v < 1 || mon_v > MaxMonth)
      return r;
    // Two-digit year window: anything before 1970 belongs to the next century
    if (year_v < WindowYear)
      year_v += CenturyYears;
    days = 0;
    if (year_v > EpochYear)
      days = longint'(year_v - EpochYear) * 365 + (year_v - 1) / 4 - (EpochYear - 1) / 4;
    if (year_v % 4 == 0 && mon_v > 2)
      days += 1;
    case (mon_v)
      1:       month_start = 0;
      2:       month_start = 31;
      3:       month_start = 59;
      4:       month_start = 90;
      5:       month_start = 120;
      6:       month_start = 151;
      7:       month_start = 181;
      8:       month_start = 212;
      9:       month_start = 243;
      10:      month_start = 273;
      11:      month_start = 304;
      default: month_start = 334;
    endcase
    days += month_start + day_v - 1;
    total = ((days * 24 + hour_v) * 60 + min_v) * 60 + sec_v;
    r.secs = total[SecW-1:0];
    r.ok   = 1'b1;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Encode a value (0..99 in BCD, 0..255 in binary) as the RTC would hold it in the current mode
  function automatic logic [FieldW-1:0] pack_field(input int unsigned v, input bit binary);
    if (binary)
      return FieldW'(v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // Mostly plausible calendars with random content; some with one field out
  // of range, and some pure noise so that every byte value turns up.
  function automatic rtc_snapshot_t random_snapshot(input bit binary);
    rtc_snapshot_t s;
    int unsigned   roll;
    int unsigned   top;
    roll = $urandom_range(99);
    top  = binary ? 255 : 99;
    if (roll < 15) begin
      s = {$urandom(), 16'($urandom())};
      return s;
    end
    s.second_b = pack_field($urandom_range(7) == 0 ? $urandom_range(top) : $urandom_range(59),
                            binary);
    s.minute_b = pack_field($urandom_range(7) == 0 ? $urandom_range(top) : $urandom_range(59),
                            binary);
    s.hour_b   = pack_field($urandom_range(23), binary);
    s.day_b    = pack_field($urandom_range(1, 31), binary);
    s.month_b  = pack_field($urandom_range(1, 12), binary);
    s.year_b   = pack_field($urandom_range(top), binary);
    if (roll < 30) begin
      case ($urandom_range(4))
        0:       s.hour_b  = pack_field($urandom_range(24, top), binary);
        1:       s.day_b   = pack_field(0, binary);
        2:       s.day_b   = pack_field($urandom_range(32, top), binary);
        3:       s.month_b = pack_field(0, binary);
        default: s.month_b = pack_field($urandom_range(13, top), binary);
      endcase
    end
    return s;
  endfunction

  task automatic queue_snapshot(input logic [7:0] sec, input logic [7:0] min,
                                input logic [7:0] hour, input logic [7:0] day,
                                input logic [7:0] month, input logic [7:0] year);
    snapshots_pending.push_back({sec, min, hour, day, month, year});
  endtask

  task automatic queue_random(input int unsigned count);
    @(negedge clk_i);
    repeat (count) snapshots_pending.push_back(random_snapshot(cfg_binary));
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Write one register over the configuration port, then read it back.
  task automatic set_register(input reg_idx_e idx, input bit value);
    logic [DataW-1:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(4 * int'(idx));
    pwdata  <= DataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    // pready is tied high: the write lands on this edge
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    got = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== DataW'(value))
      report_mismatch($sformatf("register %s reads 0x%0h, wrote %0d", idx.name(), got, value));
  endtask

  // Wait until the pipeline is empty, then change settings and flow control.
  task automatic start_phase(input bit present, input bit binary, input int unsigned send_pct,
                             input int unsigned stall_pct, input bit hold);
    while (snapshots_pending.size() != 0 || conversions_due.size() != 0 || in_valid_i)
      @(posedge clk_i);
    set_register(RegClockPresent, present);
    set_register(RegBinaryFields, binary);
    @(posedge clk_i);
    cfg_present    <= present;
    cfg_binary     <= binary;
    send_idle_pct  <= send_pct;
    recv_stall_pct <= stall_pct;
    hold_wanted    <= hold;
    settings_run++;
  endtask

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Input driver: offer the next pending snapshot once the current word has
  // gone, and predict each word at the edge on which it is taken.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_snapshots
    rtc_snapshot_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        conversions_due.push_back(calendar_to_seconds(
            {second_raw_i, minute_raw_i, hour_raw_i, day_raw_i, month_raw_i, year_raw_i},
            cfg_present, cfg_binary));
        words_in <= words_in + 1;
      end
      // Hold a stalled word; otherwise load the next one or go idle
      if (!in_valid_i || !in_stall_o) begin
        if (snapshots_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = snapshots_pending.pop_front();
          in_valid_i   <= 1'b1;
          second_raw_i <= nxt.second_b;
          minute_raw_i <= nxt.minute_b;
          hour_raw_i   <= nxt.hour_b;
          day_raw_i    <= nxt.day_b;
          month_raw_i  <= nxt.month_b;
          year_raw_i   <= nxt.year_b;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall: random back-pressure, plus a single long hold-off on request
  // so that the pipeline fills and pushes back on the sender.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_stall
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_wanted && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= HoldCycles - 1;
      hold_done   <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare each taken result with the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    epoch_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_out <= words_out + 1;
      if (valid_res_o)
        valid_seen++;
      else
        rejected_seen++;
      if (conversions_due.size() == 0) begin
        report_mismatch($sformatf("result %0d / valid %b with no conversion pending",
                                  epoch_seconds_o, valid_res_o));
      end else begin
        want = conversions_due.pop_front();
        if (epoch_seconds_o !== want.secs)
          report_mismatch($sformatf("epoch_seconds %0d, predicted %0d",
                                    epoch_seconds_o, want.secs));
        if (valid_res_o !== want.ok)
          report_mismatch($sformatf("valid_res %b, predicted %b", valid_res_o, want.ok));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: give up once nothing has moved for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watchdog
    if (words_in != seen_in || words_out != seen_out || psel) begin
      seen_in      <= words_in;
      seen_out     <= words_out;
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Watchdog: no word moved for %0d cycles, %0d conversions outstanding",
               QuietLimit, conversions_due.size());
      $display("** rtc_calendar_to_epoch_seconds_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words: BCD, clock present, no idling
    start_phase(1'b1, 1'b0, 0, 0, 1'b0);
    @(negedge clk_i);
    queue_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70);  // the epoch itself
    queue_snapshot(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69);  // last day of the window
    queue_snapshot(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99);  // end of the last century
    queue_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00);  // year 00 means 2000
    queue_snapshot(8'h56, 8'h34, 8'h12, 8'h29, 8'h02, 8'h00);  // leap day
    queue_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00);  // after a leap day
    queue_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01);  // non-leap March
    queue_snapshot(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h72);  // first leap day
    queue_snapshot(8'h00, 8'h00, 8'h00, 8'h31, 8'h02, 8'h01);  // day past month end
    queue_snapshot(8'h99, 8'h75, 8'h05, 8'h15, 8'h06, 8'h30);  // seconds and minutes too big
    queue_snapshot(8'hFF, 8'hFF, 8'h23, 8'h31, 8'h12, 8'hFF);  // nibbles above nine
    queue_snapshot(8'h00, 8'h00, 8'h1A, 8'h1F, 8'h0B, 8'h45);  // odd nibbles still in range
    queue_snapshot(8'h00, 8'h00, 8'h24, 8'h01, 8'h01, 8'h70);  // hour too big
    queue_snapshot(8'h00, 8'h00, 8'h2A, 8'h01, 8'h01, 8'h70);  // hour decodes to 30
    queue_snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h70);  // day zero
    queue_snapshot(8'h00, 8'h00, 8'h00, 8'h32, 8'h01, 8'h70);  // day 32
    queue_snapshot(8'h00, 8'h00, 8'h00, 8'h2F, 8'h01, 8'h70);  // day decodes to 35
    queue_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h70);  // month zero
    queue_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h70);  // month 13
    queue_snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);  // all bytes clear
    queue_snapshot(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);  // all bytes set

    // Random phases across settings and idling patterns
    start_phase(1'b1, 1'b0, 73, 0, 1'b0);
    queue_random(260);
    start_phase(1'b1, 1'b1, 0, 73, 1'b0);
    queue_random(260);
    start_phase(1'b1, 1'b1, 25, 25, 1'b1);  // with the long hold-off
    queue_random(260);
    start_phase(1'b0, 1'b1, 0, 0, 1'b0);    // no clock: everything rejected
    queue_random(150);
    start_phase(1'b0, 1'b0, 25, 25, 1'b0);
    queue_random(150);
    start_phase(1'b1, 1'b0, 0, 0, 1'b0);
    queue_random(320);
    start_phase(1'b1, 1'b1, 25, 25, 1'b0);
    queue_random(320);

    // Drain, then wait DrainCycles for any stray result to show up
    while (snapshots_pending.size() != 0 || conversions_due.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Summary: %0d calendar words converted over %0d register settings",
             words_out, settings_run);
    $display("Summary: %0d accepted as valid, %0d rejected, %0d mismatches",
             valid_seen, rejected_seen, mismatches);
    if (mismatches == 0) begin
      $display("** rtc_calendar_to_epoch_seconds_top: PASSED **");
    end else begin
      $display("** rtc_calendar_to_epoch_seconds_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> rtc_calendar_to_epoch_seconds_top.f
hw/rtl/rtce_pkg.sv
hw/rtl/rtc_calendar_to_epoch_seconds_top.sv
hw/rtl/rtce_checker.sv
dv/tb.sv
